// ----- hw/rtl/rcppm_pkg.sv -----
// Shared types and constants for the PPM frame decoder.
`default_nettype none

package rcppm_pkg;

  // Number of centered axes (channels 0, 1 and 3)
  localparam int NUM_AXES = 3;
  localparam int SAMPLES_PER_AXIS = 10;
  localparam int CNT_W = 4;

  // Register reset values
  localparam logic [15:0] TIMER_PERIOD_RESET = 16'd60000;
  localparam logic [15:0] SYNC_THRESHOLD_RESET = 16'd10000;
  localparam logic [15:0] THROTTLE_BOTTOM_RESET = 16'd4000;
  localparam logic [15:0] CENTER_RESET = 16'd6000;

  // x / 10 for x < 2^20 as (x * magic) >> shift
  localparam logic [19:0] DIV10_MAGIC = 20'd838861;
  localparam int DIV10_SHIFT = 23;

  // Command saturation bounds
  localparam logic signed [18:0] CMD_HI = 19'sd65535;
  localparam logic signed [18:0] CMD_LO = -19'sd65535;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIMER_PERIOD    = 3'd0,
    REG_SYNC_THRESHOLD  = 3'd1,
    REG_THROTTLE_BOTTOM = 3'd2,
    REG_CENTER_AILERON  = 3'd3,
    REG_CENTER_ELEVATOR = 3'd4,
    REG_CENTER_RUDDER   = 3'd5,
    REG_AUTO_CENTER     = 3'd6
  } cfg_reg_t;

  // How the command of a channel is formed
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_THROTTLE,
    KIND_AXIS,
    KIND_RAW
  } ch_kind_t;

  // Item as it travels down the pipeline after channel assignment
  typedef struct packed {
    logic               sync;
    logic               chan_valid;
    logic [3:0]         chan_idx;
    ch_kind_t           kind;
    logic [1:0]         axis;
    logic               learn;
    logic               tenth;
    logic               calibrated;
    logic signed [17:0] len;
    logic [15:0]        sample;
  } rcppm_item_t;

  // Center register write toward the command stage
  typedef struct packed {
    logic [NUM_AXES-1:0] load;
    logic [15:0]         value;
  } center_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcppm_front.sv -----
// Front end: stamp difference, wrap fix, sync detect, channel sequencer and calibration counts.
`default_nettype none

module rcppm_front #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [15:0]            in_capture_time,
  input  wire logic [15:0]            timer_period,
  input  wire logic [15:0]            sync_threshold,
  input  wire logic                   auto_center_enable,
  output logic                        item_valid,
  input  wire logic                   item_ready,
  output rcppm_pkg::rcppm_item_t      item
);
  import rcppm_pkg::*;

  localparam int ChW = $clog2(MAX_CHANNELS + 1);

  logic [15:0]          prev_stamp_r;
  logic                 diff_v_r;
  logic [16:0]          diff_r;
  logic [16:0]          diff_nxt;
  logic                 accept;
  logic                 fire1;

  logic [ChW-1:0]       next_ch_r, next_ch_nxt;
  logic [CNT_W-1:0]     sample_cnt_r [NUM_AXES];
  logic [CNT_W-1:0]     sample_cnt_nxt [NUM_AXES];
  logic [1:0]           axes_done_r, axes_done_nxt;
  logic                 cal_flag_r, cal_flag_nxt;
  logic                 item_v_r;
  rcppm_item_t          item_r;
  rcppm_item_t          it;

  logic signed [17:0]   len;
  logic                 is_sync;

  // Stage 0: raw difference, the borrow bit marks a timer wrap
  assign diff_nxt = {1'b0, in_capture_time} - {1'b0, prev_stamp_r};
  assign fire1    = diff_v_r && (!item_v_r || item_ready);
  assign in_ready = !diff_v_r || fire1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_stamp_r <= '0;
      diff_v_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        diff_v_r <= in_valid;
      end
      if (accept) begin
        prev_stamp_r <= in_capture_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= diff_nxt;
    end
  end

  // Stage 1: pulse length and sync compare
  assign len = $signed({diff_r[16], diff_r})
             + $signed({2'b00, (diff_r[16] ? timer_period : 16'd0)});
  assign is_sync = len > $signed({2'b00, sync_threshold});

  // Channel assignment and learning bookkeeping
  always_comb begin
    next_ch_nxt    = next_ch_r;
    sample_cnt_nxt = sample_cnt_r;
    axes_done_nxt  = axes_done_r;
    cal_flag_nxt   = cal_flag_r;
    it             = '0;
    it.kind        = KIND_NONE;
    it.len         = len;
    it.sample      = len[17] ? 16'd0 : len[15:0];

    if (is_sync) begin
      it.sync     = 1'b1;
      next_ch_nxt = '0;
    end else if (next_ch_r < ChW'(MAX_CHANNELS)) begin
      it.chan_valid = 1'b1;
      it.chan_idx   = 4'(next_ch_r);
      next_ch_nxt   = next_ch_r + 1'b1;
      case (next_ch_r)
        ChW'(0): begin
          it.kind = KIND_AXIS;
          it.axis = 2'd0;
        end
        ChW'(1): begin
          it.kind = KIND_AXIS;
          it.axis = 2'd1;
        end
        ChW'(2): it.kind = KIND_THROTTLE;
        ChW'(3): begin
          it.kind = KIND_AXIS;
          it.axis = 2'd2;
        end
        default: it.kind = KIND_RAW;
      endcase
    end

    // Learn while enabled, not yet calibrated and the axis has room
    if (it.kind == KIND_AXIS && auto_center_enable && !cal_flag_r
        && sample_cnt_r[it.axis] < CNT_W'(SAMPLES_PER_AXIS)) begin
      it.learn = 1'b1;
      sample_cnt_nxt[it.axis] = sample_cnt_r[it.axis] + 1'b1;
      if (sample_cnt_r[it.axis] == CNT_W'(SAMPLES_PER_AXIS - 1)) begin
        it.tenth = 1'b1;
        if (axes_done_r != 2'(NUM_AXES)) begin
          axes_done_nxt = axes_done_r + 1'b1;
        end
        if (axes_done_nxt == 2'(NUM_AXES)) begin
          cal_flag_nxt = 1'b1;
        end
      end
    end

    it.calibrated = cal_flag_nxt || !auto_center_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ch_r   <= '0;
      axes_done_r <= '0;
      cal_flag_r  <= 1'b0;
      item_v_r    <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sample_cnt_r[i] <= '0;
      end
    end else begin
      if (!item_v_r || item_ready) begin
        item_v_r <= diff_v_r;
      end
      if (fire1) begin
        next_ch_r    <= next_ch_nxt;
        axes_done_r  <= axes_done_nxt;
        cal_flag_r   <= cal_flag_nxt;
        sample_cnt_r <= sample_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      item_r <= it;
    end
  end

  assign item_valid = item_v_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rcppm_learn.sv -----
// Center learning: per-axis accumulators and the divide by ten.
`default_nettype none

module rcppm_learn (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire rcppm_pkg::rcppm_item_t item,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output rcppm_pkg::rcppm_item_t      res_item,
  output logic [15:0]                 res_quot
);
  import rcppm_pkg::*;

  logic [19:0]  acc_r [NUM_AXES];
  logic [19:0]  acc_sum;
  logic         s3_v_r, s4_v_r;
  rcppm_item_t  s3_item_r, s4_item_r;
  logic [19:0]  s3_sum_r;
  logic [15:0]  s4_quot_r;
  logic [39:0]  prod;
  logic         rdy3, rdy4, fire2, fire3;

  // Backpressure through the two stages
  assign rdy4       = !s4_v_r || res_ready;
  assign rdy3       = !s3_v_r || rdy4;
  assign item_ready = rdy3;
  assign fire2      = item_valid && rdy3;
  assign fire3      = s3_v_r && rdy4;

  // Stage 2: accumulate the clamped sample
  assign acc_sum = acc_r[item.axis] + {4'b0000, item.sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (rdy3) begin
        s3_v_r <= item_valid;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (fire2 && item.learn) begin
        acc_r[item.axis] <= acc_sum;
      end
    end
  end

  // Stage 3: truncating divide by ten via reciprocal multiply
  assign prod = 40'(s3_sum_r) * 40'(DIV10_MAGIC);

  always_ff @(posedge clk) begin
    if (fire2) begin
      s3_item_r <= item;
      s3_sum_r  <= acc_sum;
    end
    if (fire3) begin
      s4_item_r <= s3_item_r;
      s4_quot_r <= prod[DIV10_SHIFT +: 16];
    end
  end

  assign res_valid = s4_v_r;
  assign res_item  = s4_item_r;
  assign res_quot  = s4_quot_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rcppm_cmd.sv -----
// Command stage: learned centers, offset/center subtract, saturation and output register.
`default_nettype none

module rcppm_cmd (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire rcppm_pkg::rcppm_item_t item,
  input  wire logic [15:0]            quot,
  input  wire logic [15:0]            throttle_bottom,
  input  wire rcppm_pkg::center_wr_t  center_wr,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_frame_sync,
  output logic                        out_channel_valid,
  output logic [3:0]                  out_channel_index,
  output logic signed [16:0]          out_command,
  output logic                        out_calibrated
);
  import rcppm_pkg::*;

  logic [15:0]          center_r [NUM_AXES];
  logic [15:0]          center_sel;
  logic [15:0]          operand;
  logic signed [18:0]   diff;
  logic signed [16:0]   cmd;
  logic                 fire;

  logic                 out_valid_r;
  logic                 frame_sync_r;
  logic                 channel_valid_r;
  logic [3:0]           channel_index_r;
  logic signed [16:0]   command_r;
  logic                 calibrated_r;

  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;

  // The tenth sample of an axis already uses its new center
  assign center_sel = item.tenth ? quot : center_r[item.axis];

  always_comb begin
    case (item.kind)
      KIND_THROTTLE: operand = throttle_bottom;
      KIND_AXIS:     operand = center_sel;
      default:       operand = 16'd0;
    endcase
  end

  assign diff = $signed({item.len[17], item.len}) - $signed({3'b000, operand});

  // Command shaping per channel kind
  always_comb begin
    case (item.kind)
      KIND_THROTTLE: begin
        cmd = (!diff[18] && diff != '0) ? diff[16:0] : 17'sd0;
      end
      KIND_AXIS: begin
        if (diff > CMD_HI) begin
          cmd = 17'(CMD_HI);
        end else if (diff < CMD_LO) begin
          cmd = 17'(CMD_LO);
        end else begin
          cmd = diff[16:0];
        end
      end
      KIND_RAW: cmd = item.len[16:0];
      default:  cmd = 17'sd0;
    endcase
  end

  // Learned centers: reset and register writes load, the tenth sample updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        center_r[i] <= CENTER_RESET;
      end
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (center_wr.load[i]) begin
          center_r[i] <= center_wr.value;
        end
      end
      if (fire && item.tenth) begin
        center_r[item.axis] <= quot;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_sync_r    <= item.sync;
      channel_valid_r <= item.chan_valid;
      channel_index_r <= item.chan_idx;
      command_r       <= cmd;
      calibrated_r    <= item.calibrated;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_sync    = frame_sync_r;
  assign out_channel_valid = channel_valid_r;
  assign out_channel_index = channel_index_r;
  assign out_command       = command_r;
  assign out_calibrated    = calibrated_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rc_ppm_frame_decoder.sv -----
// Top level of the PPM frame decoder: configuration registers and pipeline wiring.
//
// Usage: each input item is one 16-bit timer capture stamp taken at a PPM edge
// (in_valid/in_ready). The block measures the pulse length from the previous
// stamp, adding timer_period when the timer wrapped. A length above
// sync_threshold restarts the frame; otherwise the length is assigned to the
// next channel and turned into a command (throttle offset, centered axis, or
// raw). Channels past MAX_CHANNELS give an empty result. Every item gives
// exactly one result item (out_valid/out_ready).
// Throughput: one item per cycle while the receiver takes results; items
// pass five register stages (difference, channel assign, accumulate,
// divide-by-ten multiply, command). Reset (rst_n low at a clock edge)
// restores register defaults, clears the channel counter, the learning
// counts and accumulators, and loads the learned centers from the center
// defaults. Configuration writes (cfg_wen/cfg_index/cfg_wdata) take effect
// at once; the user must make them while idle, the block does not enforce
// it. When the receiver stalls, items keep entering until every stage is
// full; then in_ready drops. No item is lost or repeated.
`default_nettype none

module rc_ppm_frame_decoder #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_capture_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_frame_sync,
  output logic                    out_channel_valid,
  output logic [3:0]              out_channel_index,
  output logic signed [16:0]      out_command,
  output logic                    out_calibrated,
  input  wire logic               cfg_wen,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  import rcppm_pkg::*;

  logic [15:0]  timer_period_r;
  logic [15:0]  sync_threshold_r;
  logic [15:0]  throttle_bottom_r;
  logic         auto_center_r;
  center_wr_t   center_wr;

  logic         s2_valid, s2_ready;
  rcppm_item_t  s2_item;
  logic         s4_valid, s4_ready;
  rcppm_item_t  s4_item;
  logic [15:0]  s4_quot;

  // Register write decode
  always_comb begin
    center_wr.load  = '0;
    center_wr.value = cfg_wdata;
    if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_AILERON:  center_wr.load = 3'b001;
        REG_CENTER_ELEVATOR: center_wr.load = 3'b010;
        REG_CENTER_RUDDER:   center_wr.load = 3'b100;
        default:             center_wr.load = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_period_r    <= TIMER_PERIOD_RESET;
      sync_threshold_r  <= SYNC_THRESHOLD_RESET;
      throttle_bottom_r <= THROTTLE_BOTTOM_RESET;
      auto_center_r     <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMER_PERIOD:    timer_period_r    <= cfg_wdata;
        REG_SYNC_THRESHOLD:  sync_threshold_r  <= cfg_wdata;
        REG_THROTTLE_BOTTOM: throttle_bottom_r <= cfg_wdata;
        REG_AUTO_CENTER:     auto_center_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rcppm_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_capture_time    (in_capture_time),
    .timer_period       (timer_period_r),
    .sync_threshold     (sync_threshold_r),
    .auto_center_enable (auto_center_r),
    .item_valid         (s2_valid),
    .item_ready         (s2_ready),
    .item               (s2_item)
  );

  rcppm_learn u_learn (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s2_valid),
    .item_ready (s2_ready),
    .item       (s2_item),
    .res_valid  (s4_valid),
    .res_ready  (s4_ready),
    .res_item   (s4_item),
    .res_quot   (s4_quot)
  );

  rcppm_cmd u_cmd (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (s4_valid),
    .item_ready        (s4_ready),
    .item              (s4_item),
    .quot              (s4_quot),
    .throttle_bottom   (throttle_bottom_r),
    .center_wr         (center_wr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_sync    (out_frame_sync),
    .out_channel_valid (out_channel_valid),
    .out_channel_index (out_channel_index),
    .out_command       (out_command),
    .out_calibrated    (out_calibrated)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rcppm_checker.sv -----
// Port-level checks for the PPM frame decoder, bound to the top level.
`default_nettype none

module rcppm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_frame_sync,
  input wire logic               out_channel_valid,
  input wire logic [3:0]         out_channel_index,
  input wire logic signed [16:0] out_command
);

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command)
      && $stable(out_channel_index) && $stable(out_frame_sync))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Sync and channel value never in the same item
  a_sync_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_sync && out_channel_valid))
    else $error("sync item carries a channel");

  // Items without a channel carry a zero command on channel zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_channel_valid |-> out_command == 17'sd0 && out_channel_index == 4'd0)
    else $error("empty item has nonzero fields");

endmodule

bind rc_ppm_frame_decoder rcppm_checker u_rcppm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_frame_sync    (out_frame_sync),
  .out_channel_valid (out_channel_valid),
  .out_channel_index (out_channel_index),
  .out_command       (out_command)
);

`default_nettype wire
